// ===== hw/rtl/lcdw_pkg.sv =====
package lcdw_pkg;

  // Request kinds
  localparam logic [2:0] REQ_INIT = 3'd0;
  localparam logic [2:0] REQ_CMD  = 3'd1;
  localparam logic [2:0] REQ_DATA = 3'd2;
  localparam logic [2:0] REQ_POS  = 3'd3;
  localparam logic [2:0] REQ_NUM  = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_EN_HIGH  = 2'd0;
  localparam logic [1:0] CFG_EN_LOW   = 2'd1;
  localparam logic [1:0] CFG_DISP_ON  = 2'd2;
  localparam logic [1:0] CFG_CLEAR    = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Reset values of the configuration registers
  localparam logic [6:0] EN_HIGH_RST = 7'd2;
  localparam logic [6:0] EN_LOW_RST  = 7'd2;
  localparam logic [7:0] DISP_ON_RST = 8'd12;
  localparam logic [7:0] CLEAR_RST   = 8'd1;

  // Width of the number converted to decimal, and default digit limit
  localparam int NUM_BITS       = 32;
  localparam int MAX_DIGITS_DEF = 10;

  typedef struct packed {
    logic [2:0]          req_type;
    logic [7:0]          byte_value;
    logic [1:0]          row;
    logic [5:0]          column;
    logic [NUM_BITS-1:0] number;
  } in_item_t;

  typedef struct packed {
    logic [3:0] data_nibble;
    logic       register_select;
    logic       enable_level;
    logic [7:0] hold_ms;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [6:0] enable_high_ms;
    logic [6:0] enable_low_ms;
    logic [7:0] display_on_code;
    logic [7:0] clear_code;
  } cfg_t;

endpackage

// ===== hw/rtl/char_lcd_4bit_write_sequencer.sv =====
// Channel   Ports                               Transfer
// --------  ----------------------------------  ------------------------------------
// request   start, busy, in_data                start high while busy is low
// pin state out_strobe, out_data                strobe high for one cycle, no stall
// config    cfg_we, cfg_index, cfg_wdata        cfg_we high, taken at once
//
// A request runs as a short microprogram; each byte sent is four pin states,
// one per cycle. Init sends a settling state and then five bytes; a command,
// data or position request sends one byte. A number is first converted to BCD
// (binary-to-BCD, one bit per cycle), then its leading zeros are skipped and
// one byte is sent per digit; skips and digits share the MAX_DIGITS places.
// busy drops with the final pin state; the next request is taken in that cycle.
// Synchronous active-low reset clears the sequencer and restores the registers.
// A request that yields no pin states never raises busy.
module char_lcd_4bit_write_sequencer import lcdw_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_data,
  output logic                  out_strobe,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t                       cfg_r, cfg_nxt;
  logic                       bcd_start;
  logic                       bcd_busy;
  logic                       bcd_ovf;
  logic [MAX_DIGITS-1:0][3:0] digits;

  // Configuration registers: write straight through, masked to width
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_EN_HIGH: cfg_nxt.enable_high_ms  = cfg_wdata[6:0];
        CFG_EN_LOW:  cfg_nxt.enable_low_ms   = cfg_wdata[6:0];
        CFG_DISP_ON: cfg_nxt.display_on_code = cfg_wdata;
        CFG_CLEAR:   cfg_nxt.clear_code      = cfg_wdata;
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{enable_high_ms: EN_HIGH_RST, enable_low_ms: EN_LOW_RST,
                 display_on_code: DISP_ON_RST, clear_code: CLEAR_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Binary-to-decimal unit for number requests; flag values too wide for
  // MAX_DIGITS so that their leading zeros are written
  lcdw_bcd #(.MAX_DIGITS(MAX_DIGITS)) u_bcd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (bcd_start),
    .bin    (in_data.number),
    .busy   (bcd_busy),
    .ovf    (bcd_ovf),
    .digits (digits)
  );

  // Microcoded sequencer: step counter, control ROM, pin-state output register
  lcdw_seq #(.MAX_DIGITS(MAX_DIGITS)) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_item    (in_data),
    .cfg        (cfg_r),
    .busy       (busy),
    .bcd_start  (bcd_start),
    .bcd_busy   (bcd_busy),
    .bcd_ovf    (bcd_ovf),
    .digits     (digits),
    .out_strobe (out_strobe),
    .out_item   (out_data)
  );

  // A pin state only comes out of a running request
  a_strobe_in_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("pin state emitted outside a request");

  // The request ends exactly with its final pin state
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (out_strobe && out_data.last))
    else $error("request ended without a final pin state");

  // The final pin state always leaves enable low
  a_last_enable_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.last) |-> !out_data.enable_level)
    else $error("final pin state with enable high");

  // No new request while the BCD unit still works for the previous one
  a_bcd_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    bcd_start |-> !bcd_busy)
    else $error("conversion restarted while busy");

endmodule

// ===== hw/rtl/lcdw_bcd.sv =====
module lcdw_bcd import lcdw_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [NUM_BITS-1:0]          bin,
  output logic                         busy,
  output logic                         ovf,
  output logic [MAX_DIGITS-1:0][3:0]   digits
);

  localparam int CNT_W = $clog2(NUM_BITS);

  logic [NUM_BITS-1:0]        bin_r, bin_nxt;
  logic [MAX_DIGITS-1:0][3:0] bcd_r, bcd_nxt;
  logic [MAX_DIGITS-1:0][3:0] adj;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       ovf_r, ovf_nxt;

  // One shift-and-add-3 step per cycle; only the low digits are kept,
  // which leaves the value modulo the digit range.
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      adj[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
  end

  // ovf marks a value with more decimal digits than are kept: a set bit
  // shifted out of the top digit means the dropped digits are not all zero.
  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    ovf_nxt  = ovf_r;
    if (start) begin
      bin_nxt  = bin;
      bcd_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      ovf_nxt  = 1'b0;
    end else if (busy_r) begin
      bin_nxt = {bin_r[NUM_BITS-2:0], 1'b0};
      bcd_nxt = (MAX_DIGITS*4)'({adj, bin_r[NUM_BITS-1]});
      ovf_nxt = ovf_r | adj[MAX_DIGITS-1][3];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUM_BITS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    ovf_r <= ovf_nxt;
  end

  assign busy   = busy_r;
  assign ovf    = ovf_r;
  assign digits = bcd_r;

endmodule

// ===== hw/rtl/lcdw_seq.sv =====
module lcdw_seq import lcdw_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  in_item_t                   in_item,
  input  cfg_t                       cfg,
  output logic                       busy,
  output logic                       bcd_start,
  input  logic                       bcd_busy,
  input  logic                       bcd_ovf,
  input  logic [MAX_DIGITS-1:0][3:0] digits,
  output logic                       out_strobe,
  output out_item_t                  out_item
);

  localparam int PC_W  = 4;
  localparam int PTR_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  typedef enum logic [1:0] {UC_SETTLE, UC_SEND, UC_BCD, UC_SKIPZ} uc_op_t;
  typedef enum logic [2:0] {
    SRC_33, SRC_32, SRC_28, SRC_DISP_ON, SRC_CLEAR, SRC_BYTE, SRC_POS, SRC_DIGIT
  } uc_src_t;
  typedef enum logic [1:0] {WAIT_0, WAIT_2, WAIT_100} uc_wait_t;
  typedef enum logic [1:0] {FIN_NEXT, FIN_END, FIN_LOOP} uc_fin_t;

  typedef struct packed {
    uc_op_t    op;
    uc_src_t   src;
    logic      rs;
    uc_wait_t  wt;
    uc_fin_t   fin;
    logic [PC_W-1:0] target;
  } uc_word_t;

  // Program entry points and the digit-loop target
  localparam logic [PC_W-1:0] PC_INIT = 4'd0;
  localparam logic [PC_W-1:0] PC_CMD  = 4'd6;
  localparam logic [PC_W-1:0] PC_DATA = 4'd7;
  localparam logic [PC_W-1:0] PC_POS  = 4'd8;
  localparam logic [PC_W-1:0] PC_NUM  = 4'd9;
  localparam logic [PC_W-1:0] PC_DIG  = 4'd11;

  localparam logic [7:0] SETTLE_MS = 8'd20;

  function automatic uc_word_t uc_rom(input logic [PC_W-1:0] a);
    uc_word_t w;
    w = '{op: UC_SEND, src: SRC_BYTE, rs: 1'b0, wt: WAIT_0, fin: FIN_END, target: '0};
    case (a)
      4'd0:  w = '{UC_SETTLE, SRC_BYTE,    1'b0, WAIT_0,   FIN_NEXT, 4'd0};
      4'd1:  w = '{UC_SEND,   SRC_33,      1'b0, WAIT_100, FIN_NEXT, 4'd0};
      4'd2:  w = '{UC_SEND,   SRC_32,      1'b0, WAIT_100, FIN_NEXT, 4'd0};
      4'd3:  w = '{UC_SEND,   SRC_28,      1'b0, WAIT_2,   FIN_NEXT, 4'd0};
      4'd4:  w = '{UC_SEND,   SRC_DISP_ON, 1'b0, WAIT_100, FIN_NEXT, 4'd0};
      4'd5:  w = '{UC_SEND,   SRC_CLEAR,   1'b0, WAIT_2,   FIN_END,  4'd0};
      4'd6:  w = '{UC_SEND,   SRC_BYTE,    1'b0, WAIT_0,   FIN_END,  4'd0};
      4'd7:  w = '{UC_SEND,   SRC_BYTE,    1'b1, WAIT_0,   FIN_END,  4'd0};
      4'd8:  w = '{UC_SEND,   SRC_POS,     1'b0, WAIT_0,   FIN_END,  4'd0};
      4'd9:  w = '{UC_BCD,    SRC_BYTE,    1'b0, WAIT_0,   FIN_NEXT, 4'd0};
      4'd10: w = '{UC_SKIPZ,  SRC_BYTE,    1'b0, WAIT_0,   FIN_NEXT, 4'd0};
      4'd11: w = '{UC_SEND,   SRC_DIGIT,   1'b1, WAIT_0,   FIN_LOOP, PC_DIG};
      default: w = '{UC_SEND, SRC_BYTE,    1'b0, WAIT_0,   FIN_END,  4'd0};
    endcase
    return w;
  endfunction

  logic [PC_W-1:0]  pc_r, pc_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic             running_r, running_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic             row2_r, row2_nxt;
  logic [5:0]       col_r, col_nxt;
  logic             out_strobe_r, out_strobe_nxt;
  out_item_t        out_item_r, out_item_nxt;

  uc_word_t         uw;
  logic             accept;
  logic             req_ok;
  logic [PC_W-1:0]  entry;
  logic [7:0]       send_byte;
  logic [3:0]       digit;
  logic [7:0]       extra;
  logic [7:0]       hold;
  logic             is_end;

  assign uw     = uc_rom(pc_r);
  assign accept = start && !running_r;
  assign digit  = digits[ptr_r];

  always_comb begin
    req_ok = 1'b1;
    entry  = PC_INIT;
    case (in_item.req_type)
      REQ_INIT: entry = PC_INIT;
      REQ_CMD:  entry = PC_CMD;
      REQ_DATA: entry = PC_DATA;
      REQ_POS: begin
        entry  = PC_POS;
        req_ok = (in_item.row == 2'd1) || (in_item.row == 2'd2);
      end
      REQ_NUM:  entry = PC_NUM;
      default:  req_ok = 1'b0;
    endcase
  end

  always_comb begin
    case (uw.src)
      SRC_33:      send_byte = 8'h33;
      SRC_32:      send_byte = 8'h32;
      SRC_28:      send_byte = 8'h28;
      SRC_DISP_ON: send_byte = cfg.display_on_code;
      SRC_CLEAR:   send_byte = cfg.clear_code;
      SRC_BYTE:    send_byte = byte_r;
      SRC_POS:     send_byte = {1'b1, row2_r, col_r};
      SRC_DIGIT:   send_byte = {4'h3, digit};
      default:     send_byte = byte_r;
    endcase
    case (uw.wt)
      WAIT_2:   extra = 8'd2;
      WAIT_100: extra = 8'd100;
      default:  extra = 8'd0;
    endcase
    // Enable-low state after the low nibble carries the command's extra wait
    if (phase_r[0]) begin
      hold = {1'b0, cfg.enable_low_ms} + ((phase_r == 2'd3) ? extra : 8'd0);
    end else begin
      hold = {1'b0, cfg.enable_high_ms};
    end
    is_end = (uw.fin == FIN_END) || ((uw.fin == FIN_LOOP) && (ptr_r == '0));
  end

  always_comb begin
    pc_nxt         = pc_r;
    phase_nxt      = phase_r;
    ptr_nxt        = ptr_r;
    running_nxt    = running_r;
    byte_nxt       = byte_r;
    row2_nxt       = row2_r;
    col_nxt        = col_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    bcd_start      = 1'b0;
    if (accept) begin
      byte_nxt    = in_item.byte_value;
      row2_nxt    = (in_item.row == 2'd2);
      col_nxt     = in_item.column;
      ptr_nxt     = PTR_W'(MAX_DIGITS - 1);
      phase_nxt   = 2'd0;
      pc_nxt      = entry;
      running_nxt = req_ok;
      bcd_start   = (in_item.req_type == REQ_NUM);
    end else if (running_r) begin
      case (uw.op)
        UC_SETTLE: begin
          out_strobe_nxt = 1'b1;
          out_item_nxt   = '{data_nibble: 4'd0, register_select: 1'b0,
                             enable_level: 1'b0, hold_ms: SETTLE_MS, last: 1'b0};
          pc_nxt         = pc_r + 1'b1;
        end
        UC_SEND: begin
          out_strobe_nxt = 1'b1;
          out_item_nxt   = '{data_nibble: phase_r[1] ? send_byte[3:0] : send_byte[7:4],
                             register_select: uw.rs,
                             enable_level: !phase_r[0],
                             hold_ms: hold,
                             last: (phase_r == 2'd3) && is_end};
          phase_nxt      = phase_r + 1'b1;
          if (phase_r == 2'd3) begin
            if (is_end) begin
              running_nxt = 1'b0;
            end else if (uw.fin == FIN_LOOP) begin
              ptr_nxt = ptr_r - 1'b1;
              pc_nxt  = uw.target;
            end else begin
              pc_nxt = pc_r + 1'b1;
            end
          end
        end
        UC_BCD: begin
          if (!bcd_busy) begin
            pc_nxt = pc_r + 1'b1;
          end
        end
        UC_SKIPZ: begin
          // A value cut to its low digits keeps its leading zeros
          if ((digit == 4'd0) && (ptr_r != '0) && !bcd_ovf) begin
            ptr_nxt = ptr_r - 1'b1;
          end else begin
            pc_nxt = pc_r + 1'b1;
          end
        end
        default: running_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r    <= 1'b0;
      out_strobe_r <= 1'b0;
      pc_r         <= '0;
      phase_r      <= '0;
      ptr_r        <= '0;
    end else begin
      running_r    <= running_nxt;
      out_strobe_r <= out_strobe_nxt;
      pc_r         <= pc_nxt;
      phase_r      <= phase_nxt;
      ptr_r        <= ptr_nxt;
    end
    byte_r     <= byte_nxt;
    row2_r     <= row2_nxt;
    col_r      <= col_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy       = running_r;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule
